// ===== hdl/rvdec_pkg.sv =====
// ----------------------------------------------------------------------------
// rvdec_pkg
// Types and constants shared by the RV32I decoder: opcodes, instruction
// kinds and the transfer payloads of both channels.
// ----------------------------------------------------------------------------
package rvdec_pkg;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_ALUI   = 7'h13;
  localparam logic [6:0] OP_ALUR   = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  localparam logic [6:0] FUNCT7_BASE = 7'h00;
  localparam logic [6:0] FUNCT7_ALT  = 7'h20;

  typedef enum logic [5:0] {
    KIND_ILLEGAL = 6'd0,
    KIND_LUI     = 6'd1,
    KIND_AUIPC   = 6'd2,
    KIND_JAL     = 6'd3,
    KIND_JALR    = 6'd4,
    KIND_BEQ     = 6'd5,
    KIND_BNE     = 6'd6,
    KIND_BLT     = 6'd7,
    KIND_BGE     = 6'd8,
    KIND_BLTU    = 6'd9,
    KIND_BGEU    = 6'd10,
    KIND_LB      = 6'd11,
    KIND_LH      = 6'd12,
    KIND_LW      = 6'd13,
    KIND_LBU     = 6'd14,
    KIND_LHU     = 6'd15,
    KIND_SB      = 6'd16,
    KIND_SH      = 6'd17,
    KIND_SW      = 6'd18,
    KIND_ADDI    = 6'd19,
    KIND_SLTI    = 6'd20,
    KIND_SLTIU   = 6'd21,
    KIND_XORI    = 6'd22,
    KIND_ORI     = 6'd23,
    KIND_ANDI    = 6'd24,
    KIND_SLLI    = 6'd25,
    KIND_SRLI    = 6'd26,
    KIND_SRAI    = 6'd27,
    KIND_ADD     = 6'd28,
    KIND_SUB     = 6'd29,
    KIND_SLL     = 6'd30,
    KIND_SLT     = 6'd31,
    KIND_SLTU    = 6'd32,
    KIND_XOR     = 6'd33,
    KIND_SRL     = 6'd34,
    KIND_SRA     = 6'd35,
    KIND_OR      = 6'd36,
    KIND_AND     = 6'd37,
    KIND_ECALL   = 6'd38,
    KIND_EBREAK  = 6'd39,
    KIND_CSRRW   = 6'd40,
    KIND_CSRRS   = 6'd41,
    KIND_CSRRC   = 6'd42,
    KIND_CSRRWI  = 6'd43,
    KIND_CSRRSI  = 6'd44,
    KIND_CSRRCI  = 6'd45
  } insn_kind_e;

  typedef struct packed {
    logic [31:0] instruction_word;
    logic [31:0] pc_address;
  } dec_in_t;

  typedef struct packed {
    insn_kind_e         insn_kind;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
    logic [31:0]        target_address;
    logic [11:0]        csr_number;
  } dec_out_t;

endpackage

// ===== hdl/rvdec_decode.sv =====
// ----------------------------------------------------------------------------
// rvdec_decode
// Combinational RV32I decode: kind, register fields, immediate, branch/jump
// target and CSR number. Illegal words give all-zero fields.
// ----------------------------------------------------------------------------
module rvdec_decode (
  input  rvdec_pkg::dec_in_t  dec_i,
  output rvdec_pkg::dec_out_t dec_o
);

  logic [31:0] w;
  logic [6:0]  opcode;
  logic [2:0]  funct3;
  logic [6:0]  funct7;
  logic [4:0]  rd;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_u;
  logic [31:0] tgt_b;
  logic [31:0] tgt_j;

  rvdec_pkg::insn_kind_e kind;

  assign w      = dec_i.instruction_word;
  assign opcode = w[6:0];
  assign funct3 = w[14:12];
  assign funct7 = w[31:25];
  assign rd     = w[11:7];
  assign rs1    = w[19:15];
  assign rs2    = w[24:20];

  assign imm_i = {{20{w[31]}}, w[31:20]};
  assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign imm_u = {w[31:12], 12'h000};

  assign tgt_b = dec_i.pc_address + imm_b;
  assign tgt_j = dec_i.pc_address + imm_j;

  // kind classification
  always_comb begin
    kind = rvdec_pkg::KIND_ILLEGAL;
    unique case (opcode)
      rvdec_pkg::OP_LUI:   kind = rvdec_pkg::KIND_LUI;
      rvdec_pkg::OP_AUIPC: kind = rvdec_pkg::KIND_AUIPC;
      rvdec_pkg::OP_JAL:   kind = rvdec_pkg::KIND_JAL;
      rvdec_pkg::OP_JALR:  kind = rvdec_pkg::KIND_JALR;
      rvdec_pkg::OP_BRANCH: begin
        unique case (funct3)
          3'd0:    kind = rvdec_pkg::KIND_BEQ;
          3'd1:    kind = rvdec_pkg::KIND_BNE;
          3'd4:    kind = rvdec_pkg::KIND_BLT;
          3'd5:    kind = rvdec_pkg::KIND_BGE;
          3'd6:    kind = rvdec_pkg::KIND_BLTU;
          3'd7:    kind = rvdec_pkg::KIND_BGEU;
          default: kind = rvdec_pkg::KIND_ILLEGAL;
        endcase
      end
      rvdec_pkg::OP_LOAD: begin
        unique case (funct3)
          3'd0:    kind = rvdec_pkg::KIND_LB;
          3'd1:    kind = rvdec_pkg::KIND_LH;
          3'd2:    kind = rvdec_pkg::KIND_LW;
          3'd4:    kind = rvdec_pkg::KIND_LBU;
          3'd5:    kind = rvdec_pkg::KIND_LHU;
          default: kind = rvdec_pkg::KIND_ILLEGAL;
        endcase
      end
      rvdec_pkg::OP_STORE: begin
        unique case (funct3)
          3'd0:    kind = rvdec_pkg::KIND_SB;
          3'd1:    kind = rvdec_pkg::KIND_SH;
          3'd2:    kind = rvdec_pkg::KIND_SW;
          default: kind = rvdec_pkg::KIND_ILLEGAL;
        endcase
      end
      rvdec_pkg::OP_ALUI: begin
        unique case (funct3)
          3'd0: kind = rvdec_pkg::KIND_ADDI;
          3'd1: kind = rvdec_pkg::KIND_SLLI;
          3'd2: kind = rvdec_pkg::KIND_SLTI;
          3'd3: kind = rvdec_pkg::KIND_SLTIU;
          3'd4: kind = rvdec_pkg::KIND_XORI;
          3'd5: begin
            priority if (funct7 == rvdec_pkg::FUNCT7_BASE) kind = rvdec_pkg::KIND_SRLI;
            else if (funct7 == rvdec_pkg::FUNCT7_ALT)      kind = rvdec_pkg::KIND_SRAI;
            else                                           kind = rvdec_pkg::KIND_ILLEGAL;
          end
          3'd6: kind = rvdec_pkg::KIND_ORI;
          3'd7: kind = rvdec_pkg::KIND_ANDI;
          default: kind = rvdec_pkg::KIND_ILLEGAL;
        endcase
      end
      rvdec_pkg::OP_ALUR: begin
        unique case (funct3)
          3'd0: begin
            priority if (funct7 == rvdec_pkg::FUNCT7_BASE) kind = rvdec_pkg::KIND_ADD;
            else if (funct7 == rvdec_pkg::FUNCT7_ALT)      kind = rvdec_pkg::KIND_SUB;
            else                                           kind = rvdec_pkg::KIND_ILLEGAL;
          end
          3'd1: kind = rvdec_pkg::KIND_SLL;
          3'd2: kind = rvdec_pkg::KIND_SLT;
          3'd3: kind = rvdec_pkg::KIND_SLTU;
          3'd4: kind = rvdec_pkg::KIND_XOR;
          3'd5: begin
            priority if (funct7 == rvdec_pkg::FUNCT7_BASE) kind = rvdec_pkg::KIND_SRL;
            else if (funct7 == rvdec_pkg::FUNCT7_ALT)      kind = rvdec_pkg::KIND_SRA;
            else                                           kind = rvdec_pkg::KIND_ILLEGAL;
          end
          3'd6: kind = rvdec_pkg::KIND_OR;
          3'd7: kind = rvdec_pkg::KIND_AND;
          default: kind = rvdec_pkg::KIND_ILLEGAL;
        endcase
      end
      rvdec_pkg::OP_SYSTEM: begin
        unique case (funct3)
          3'd0: begin
            priority if (w == rvdec_pkg::WORD_ECALL) kind = rvdec_pkg::KIND_ECALL;
            else if (w == rvdec_pkg::WORD_EBREAK)    kind = rvdec_pkg::KIND_EBREAK;
            else                                     kind = rvdec_pkg::KIND_ILLEGAL;
          end
          3'd1:    kind = rvdec_pkg::KIND_CSRRW;
          3'd2:    kind = rvdec_pkg::KIND_CSRRS;
          3'd3:    kind = rvdec_pkg::KIND_CSRRC;
          3'd5:    kind = rvdec_pkg::KIND_CSRRWI;
          3'd6:    kind = rvdec_pkg::KIND_CSRRSI;
          3'd7:    kind = rvdec_pkg::KIND_CSRRCI;
          default: kind = rvdec_pkg::KIND_ILLEGAL;
        endcase
      end
      default: kind = rvdec_pkg::KIND_ILLEGAL;
    endcase
  end

  // field selection per kind
  always_comb begin
    dec_o                = '0;
    dec_o.insn_kind      = kind;
    unique case (kind)
      rvdec_pkg::KIND_LUI, rvdec_pkg::KIND_AUIPC: begin
        dec_o.dest_reg  = rd;
        dec_o.immediate = imm_u;
      end
      rvdec_pkg::KIND_JAL: begin
        dec_o.dest_reg       = rd;
        dec_o.immediate      = imm_j;
        dec_o.target_address = tgt_j;
      end
      rvdec_pkg::KIND_JALR, rvdec_pkg::KIND_LB, rvdec_pkg::KIND_LH, rvdec_pkg::KIND_LW,
      rvdec_pkg::KIND_LBU, rvdec_pkg::KIND_LHU, rvdec_pkg::KIND_ADDI, rvdec_pkg::KIND_SLTI,
      rvdec_pkg::KIND_SLTIU, rvdec_pkg::KIND_XORI, rvdec_pkg::KIND_ORI,
      rvdec_pkg::KIND_ANDI: begin
        dec_o.dest_reg  = rd;
        dec_o.src1_reg  = rs1;
        dec_o.immediate = imm_i;
      end
      rvdec_pkg::KIND_SLLI, rvdec_pkg::KIND_SRLI, rvdec_pkg::KIND_SRAI: begin
        dec_o.dest_reg  = rd;
        dec_o.src1_reg  = rs1;
        dec_o.immediate = {27'd0, rs2};
      end
      rvdec_pkg::KIND_BEQ, rvdec_pkg::KIND_BNE, rvdec_pkg::KIND_BLT, rvdec_pkg::KIND_BGE,
      rvdec_pkg::KIND_BLTU, rvdec_pkg::KIND_BGEU: begin
        dec_o.src1_reg       = rs1;
        dec_o.src2_reg       = rs2;
        dec_o.immediate      = imm_b;
        dec_o.target_address = tgt_b;
      end
      rvdec_pkg::KIND_SB, rvdec_pkg::KIND_SH, rvdec_pkg::KIND_SW: begin
        dec_o.src1_reg  = rs1;
        dec_o.src2_reg  = rs2;
        dec_o.immediate = imm_s;
      end
      rvdec_pkg::KIND_ADD, rvdec_pkg::KIND_SUB, rvdec_pkg::KIND_SLL, rvdec_pkg::KIND_SLT,
      rvdec_pkg::KIND_SLTU, rvdec_pkg::KIND_XOR, rvdec_pkg::KIND_SRL, rvdec_pkg::KIND_SRA,
      rvdec_pkg::KIND_OR, rvdec_pkg::KIND_AND: begin
        dec_o.dest_reg = rd;
        dec_o.src1_reg = rs1;
        dec_o.src2_reg = rs2;
      end
      rvdec_pkg::KIND_CSRRW, rvdec_pkg::KIND_CSRRS, rvdec_pkg::KIND_CSRRC,
      rvdec_pkg::KIND_CSRRWI, rvdec_pkg::KIND_CSRRSI, rvdec_pkg::KIND_CSRRCI: begin
        dec_o.dest_reg   = rd;
        dec_o.src1_reg   = rs1;
        dec_o.csr_number = w[31:20];
      end
      default: begin
        dec_o.dest_reg = '0;
      end
    endcase
  end

endmodule

// ===== hdl/rv32i_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder
// Registered RV32I decoder with valid/ready channels on both sides.
// ----------------------------------------------------------------------------
// Takes one instruction word and its address per transfer and returns one
// decoded result per transfer. An input register feeds the decode logic,
// whose output lands in a result register, so each result passes through
// both registers in turn before it is offered. While the output side takes
// results, a new word is accepted every cycle: one item per clock, set by
// the single decode pass between the two registers. Ready on the input side
// drops only while both registers hold items and the output side stalls.
// Illegal words decode to kind 0 with all other fields 0.
module rv32i_instruction_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rvdec_pkg::dec_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rvdec_pkg::dec_out_t out_data_o
);

  logic                in_valid_q;
  rvdec_pkg::dec_in_t  in_data_q;
  logic                out_valid_q;
  rvdec_pkg::dec_out_t out_data_q;
  rvdec_pkg::dec_out_t dec_result;
  logic                out_load;

  assign out_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || out_load;

  rvdec_decode u_decode (
    .dec_i (in_data_q),
    .dec_o (dec_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
    if (out_load && in_valid_q) begin
      out_data_q <= dec_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sim/tb_rv32i_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_rv32i_instruction_decoder
// Self-checking testbench for the registered RV32I instruction decoder.
// ----------------------------------------------------------------------------
// Each accepted instruction word is decoded by an independent predictor and
// queued. Every result transfer is checked field by field against the oldest
// queued decode. Stimulus starts with hand-picked corner words, then one
// legal word per instruction kind, a long output stall that fills the block,
// a pause that drains it, a large random mix of legal words and noise with
// random idling on both sides, and a final stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rv32i_instruction_decoder;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_STALL  = 300;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  rvdec_pkg::dec_in_t  in_data   = '0;
  logic                out_ready = 1'b0;
  logic                in_ready;
  logic                out_valid;
  rvdec_pkg::dec_out_t out_data;

  rvdec_pkg::dec_out_t decoded_q[$];
  int       mismatch_count = 0;
  int       quiet_cycles   = 0;
  int       rx_hold_req    = 0;
  bit       idle_en        = 1'b1;

  rv32i_instruction_decoder u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic rvdec_pkg::dec_out_t decode_insn(rvdec_pkg::dec_in_t item);
    rvdec_pkg::dec_out_t   r;
    rvdec_pkg::insn_kind_e k;
    logic [31:0] w;
    logic [31:0] offset;
    logic [31:0] imm_i;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    r     = '0;
    k     = rvdec_pkg::KIND_ILLEGAL;
    w     = item.instruction_word;
    f3    = w[14:12];
    f7    = w[31:25];
    rd    = w[11:7];
    rs1   = w[19:15];
    rs2   = w[24:20];
    imm_i = {{20{w[31]}}, w[31:20]};
    case (w[6:0])
      rvdec_pkg::OP_LUI, rvdec_pkg::OP_AUIPC: begin
        k = (w[6:0] == rvdec_pkg::OP_LUI) ? rvdec_pkg::KIND_LUI : rvdec_pkg::KIND_AUIPC;
        r.dest_reg  = rd;
        r.immediate = {w[31:12], 12'h000};
      end
      rvdec_pkg::OP_JAL: begin
        k = rvdec_pkg::KIND_JAL;
        offset = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        r.dest_reg       = rd;
        r.immediate      = offset;
        r.target_address = item.pc_address + offset;
      end
      rvdec_pkg::OP_JALR: begin
        k = rvdec_pkg::KIND_JALR;
        r.dest_reg  = rd;
        r.src1_reg  = rs1;
        r.immediate = imm_i;
      end
      rvdec_pkg::OP_BRANCH: begin
        case (f3)
          3'd0:    k = rvdec_pkg::KIND_BEQ;
          3'd1:    k = rvdec_pkg::KIND_BNE;
          3'd4:    k = rvdec_pkg::KIND_BLT;
          3'd5:    k = rvdec_pkg::KIND_BGE;
          3'd6:    k = rvdec_pkg::KIND_BLTU;
          3'd7:    k = rvdec_pkg::KIND_BGEU;
          default: k = rvdec_pkg::KIND_ILLEGAL;
        endcase
        if (k != rvdec_pkg::KIND_ILLEGAL) begin
          offset = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
          r.src1_reg       = rs1;
          r.src2_reg       = rs2;
          r.immediate      = offset;
          r.target_address = item.pc_address + offset;
        end
      end
      rvdec_pkg::OP_LOAD: begin
        case (f3)
          3'd0:    k = rvdec_pkg::KIND_LB;
          3'd1:    k = rvdec_pkg::KIND_LH;
          3'd2:    k = rvdec_pkg::KIND_LW;
          3'd4:    k = rvdec_pkg::KIND_LBU;
          3'd5:    k = rvdec_pkg::KIND_LHU;
          default: k = rvdec_pkg::KIND_ILLEGAL;
        endcase
        if (k != rvdec_pkg::KIND_ILLEGAL) begin
          r.dest_reg  = rd;
          r.src1_reg  = rs1;
          r.immediate = imm_i;
        end
      end
      rvdec_pkg::OP_STORE: begin
        case (f3)
          3'd0:    k = rvdec_pkg::KIND_SB;
          3'd1:    k = rvdec_pkg::KIND_SH;
          3'd2:    k = rvdec_pkg::KIND_SW;
          default: k = rvdec_pkg::KIND_ILLEGAL;
        endcase
        if (k != rvdec_pkg::KIND_ILLEGAL) begin
          r.src1_reg  = rs1;
          r.src2_reg  = rs2;
          r.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
        end
      end
      rvdec_pkg::OP_ALUI: begin
        case (f3)
          3'd0: k = rvdec_pkg::KIND_ADDI;
          3'd1: k = rvdec_pkg::KIND_SLLI;
          3'd2: k = rvdec_pkg::KIND_SLTI;
          3'd3: k = rvdec_pkg::KIND_SLTIU;
          3'd4: k = rvdec_pkg::KIND_XORI;
          3'd5: k = (f7 == rvdec_pkg::FUNCT7_BASE) ? rvdec_pkg::KIND_SRLI :
                    (f7 == rvdec_pkg::FUNCT7_ALT) ? rvdec_pkg::KIND_SRAI :
                    rvdec_pkg::KIND_ILLEGAL;
          3'd6: k = rvdec_pkg::KIND_ORI;
          3'd7: k = rvdec_pkg::KIND_ANDI;
        endcase
        if (k != rvdec_pkg::KIND_ILLEGAL) begin
          r.dest_reg = rd;
          r.src1_reg = rs1;
          if (k == rvdec_pkg::KIND_SLLI || k == rvdec_pkg::KIND_SRLI ||
              k == rvdec_pkg::KIND_SRAI)
            r.immediate = {27'd0, rs2};
          else
            r.immediate = imm_i;
        end
      end
      rvdec_pkg::OP_ALUR: begin
        case (f3)
          3'd0: k = (f7 == rvdec_pkg::FUNCT7_BASE) ? rvdec_pkg::KIND_ADD :
                    (f7 == rvdec_pkg::FUNCT7_ALT) ? rvdec_pkg::KIND_SUB :
                    rvdec_pkg::KIND_ILLEGAL;
          3'd1: k = rvdec_pkg::KIND_SLL;
          3'd2: k = rvdec_pkg::KIND_SLT;
          3'd3: k = rvdec_pkg::KIND_SLTU;
          3'd4: k = rvdec_pkg::KIND_XOR;
          3'd5: k = (f7 == rvdec_pkg::FUNCT7_BASE) ? rvdec_pkg::KIND_SRL :
                    (f7 == rvdec_pkg::FUNCT7_ALT) ? rvdec_pkg::KIND_SRA :
                    rvdec_pkg::KIND_ILLEGAL;
          3'd6: k = rvdec_pkg::KIND_OR;
          3'd7: k = rvdec_pkg::KIND_AND;
        endcase
        if (k != rvdec_pkg::KIND_ILLEGAL) begin
          r.dest_reg = rd;
          r.src1_reg = rs1;
          r.src2_reg = rs2;
        end
      end
      rvdec_pkg::OP_SYSTEM: begin
        case (f3)
          3'd0:    k = (w == rvdec_pkg::WORD_ECALL) ? rvdec_pkg::KIND_ECALL :
                       (w == rvdec_pkg::WORD_EBREAK) ? rvdec_pkg::KIND_EBREAK :
                       rvdec_pkg::KIND_ILLEGAL;
          3'd1:    k = rvdec_pkg::KIND_CSRRW;
          3'd2:    k = rvdec_pkg::KIND_CSRRS;
          3'd3:    k = rvdec_pkg::KIND_CSRRC;
          3'd5:    k = rvdec_pkg::KIND_CSRRWI;
          3'd6:    k = rvdec_pkg::KIND_CSRRSI;
          3'd7:    k = rvdec_pkg::KIND_CSRRCI;
          default: k = rvdec_pkg::KIND_ILLEGAL;
        endcase
        if (k != rvdec_pkg::KIND_ILLEGAL && k != rvdec_pkg::KIND_ECALL &&
            k != rvdec_pkg::KIND_EBREAK) begin
          r.dest_reg   = rd;
          r.src1_reg   = rs1;
          r.csr_number = w[31:20];
        end
      end
      default: ;
    endcase
    r.insn_kind = k;
    return r;
  endfunction

  // Builds a legal word of the given kind around random field content.
  function automatic logic [31:0] encode_kind(rvdec_pkg::insn_kind_e k, logic [31:0] body);
    logic [6:0] op;
    logic [2:0] f3;
    logic [6:0] f7;
    op = body[6:0];
    f3 = body[14:12];
    f7 = body[31:25];
    case (k)
      rvdec_pkg::KIND_LUI:    op = rvdec_pkg::OP_LUI;
      rvdec_pkg::KIND_AUIPC:  op = rvdec_pkg::OP_AUIPC;
      rvdec_pkg::KIND_JAL:    op = rvdec_pkg::OP_JAL;
      rvdec_pkg::KIND_JALR:   op = rvdec_pkg::OP_JALR;
      rvdec_pkg::KIND_BEQ:    begin op = rvdec_pkg::OP_BRANCH; f3 = 3'd0; end
      rvdec_pkg::KIND_BNE:    begin op = rvdec_pkg::OP_BRANCH; f3 = 3'd1; end
      rvdec_pkg::KIND_BLT:    begin op = rvdec_pkg::OP_BRANCH; f3 = 3'd4; end
      rvdec_pkg::KIND_BGE:    begin op = rvdec_pkg::OP_BRANCH; f3 = 3'd5; end
      rvdec_pkg::KIND_BLTU:   begin op = rvdec_pkg::OP_BRANCH; f3 = 3'd6; end
      rvdec_pkg::KIND_BGEU:   begin op = rvdec_pkg::OP_BRANCH; f3 = 3'd7; end
      rvdec_pkg::KIND_LB:     begin op = rvdec_pkg::OP_LOAD; f3 = 3'd0; end
      rvdec_pkg::KIND_LH:     begin op = rvdec_pkg::OP_LOAD; f3 = 3'd1; end
      rvdec_pkg::KIND_LW:     begin op = rvdec_pkg::OP_LOAD; f3 = 3'd2; end
      rvdec_pkg::KIND_LBU:    begin op = rvdec_pkg::OP_LOAD; f3 = 3'd4; end
      rvdec_pkg::KIND_LHU:    begin op = rvdec_pkg::OP_LOAD; f3 = 3'd5; end
      rvdec_pkg::KIND_SB:     begin op = rvdec_pkg::OP_STORE; f3 = 3'd0; end
      rvdec_pkg::KIND_SH:     begin op = rvdec_pkg::OP_STORE; f3 = 3'd1; end
      rvdec_pkg::KIND_SW:     begin op = rvdec_pkg::OP_STORE; f3 = 3'd2; end
      rvdec_pkg::KIND_ADDI:   begin op = rvdec_pkg::OP_ALUI; f3 = 3'd0; end
      rvdec_pkg::KIND_SLTI:   begin op = rvdec_pkg::OP_ALUI; f3 = 3'd2; end
      rvdec_pkg::KIND_SLTIU:  begin op = rvdec_pkg::OP_ALUI; f3 = 3'd3; end
      rvdec_pkg::KIND_XORI:   begin op = rvdec_pkg::OP_ALUI; f3 = 3'd4; end
      rvdec_pkg::KIND_ORI:    begin op = rvdec_pkg::OP_ALUI; f3 = 3'd6; end
      rvdec_pkg::KIND_ANDI:   begin op = rvdec_pkg::OP_ALUI; f3 = 3'd7; end
      rvdec_pkg::KIND_SLLI:   begin op = rvdec_pkg::OP_ALUI; f3 = 3'd1; end
      rvdec_pkg::KIND_SRLI: begin
        op = rvdec_pkg::OP_ALUI; f3 = 3'd5; f7 = rvdec_pkg::FUNCT7_BASE;
      end
      rvdec_pkg::KIND_SRAI: begin
        op = rvdec_pkg::OP_ALUI; f3 = 3'd5; f7 = rvdec_pkg::FUNCT7_ALT;
      end
      rvdec_pkg::KIND_ADD: begin
        op = rvdec_pkg::OP_ALUR; f3 = 3'd0; f7 = rvdec_pkg::FUNCT7_BASE;
      end
      rvdec_pkg::KIND_SUB: begin
        op = rvdec_pkg::OP_ALUR; f3 = 3'd0; f7 = rvdec_pkg::FUNCT7_ALT;
      end
      rvdec_pkg::KIND_SLL:    begin op = rvdec_pkg::OP_ALUR; f3 = 3'd1; end
      rvdec_pkg::KIND_SLT:    begin op = rvdec_pkg::OP_ALUR; f3 = 3'd2; end
      rvdec_pkg::KIND_SLTU:   begin op = rvdec_pkg::OP_ALUR; f3 = 3'd3; end
      rvdec_pkg::KIND_XOR:    begin op = rvdec_pkg::OP_ALUR; f3 = 3'd4; end
      rvdec_pkg::KIND_SRL: begin
        op = rvdec_pkg::OP_ALUR; f3 = 3'd5; f7 = rvdec_pkg::FUNCT7_BASE;
      end
      rvdec_pkg::KIND_SRA: begin
        op = rvdec_pkg::OP_ALUR; f3 = 3'd5; f7 = rvdec_pkg::FUNCT7_ALT;
      end
      rvdec_pkg::KIND_OR:     begin op = rvdec_pkg::OP_ALUR; f3 = 3'd6; end
      rvdec_pkg::KIND_AND:    begin op = rvdec_pkg::OP_ALUR; f3 = 3'd7; end
      rvdec_pkg::KIND_ECALL:  return rvdec_pkg::WORD_ECALL;
      rvdec_pkg::KIND_EBREAK: return rvdec_pkg::WORD_EBREAK;
      rvdec_pkg::KIND_CSRRW:  begin op = rvdec_pkg::OP_SYSTEM; f3 = 3'd1; end
      rvdec_pkg::KIND_CSRRS:  begin op = rvdec_pkg::OP_SYSTEM; f3 = 3'd2; end
      rvdec_pkg::KIND_CSRRC:  begin op = rvdec_pkg::OP_SYSTEM; f3 = 3'd3; end
      rvdec_pkg::KIND_CSRRWI: begin op = rvdec_pkg::OP_SYSTEM; f3 = 3'd5; end
      rvdec_pkg::KIND_CSRRSI: begin op = rvdec_pkg::OP_SYSTEM; f3 = 3'd6; end
      rvdec_pkg::KIND_CSRRCI: begin op = rvdec_pkg::OP_SYSTEM; f3 = 3'd7; end
      default:     ;
    endcase
    return {f7, body[24:15], f3, body[11:7], op};
  endfunction

  function automatic logic [6:0] pick_opcode();
    case ($urandom_range(0, 9))
      0:       return rvdec_pkg::OP_LUI;
      1:       return rvdec_pkg::OP_AUIPC;
      2:       return rvdec_pkg::OP_JAL;
      3:       return rvdec_pkg::OP_JALR;
      4:       return rvdec_pkg::OP_BRANCH;
      5:       return rvdec_pkg::OP_LOAD;
      6:       return rvdec_pkg::OP_STORE;
      7:       return rvdec_pkg::OP_ALUI;
      8:       return rvdec_pkg::OP_ALUR;
      default: return rvdec_pkg::OP_SYSTEM;
    endcase
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    w   = $urandom();
    if (sel < 75) begin
      w = encode_kind(rvdec_pkg::insn_kind_e'($urandom_range(1, 45)), w);
    end else if (sel < 87) begin
      // legal opcode, anything else: hits bad funct3 and funct7
      w[6:0] = pick_opcode();
    end else if (sel < 93) begin
      // near misses on ecall and ebreak
      w = ($urandom_range(0, 1) ? rvdec_pkg::WORD_ECALL : rvdec_pkg::WORD_EBREAK)
          ^ (32'h1 << $urandom_range(7, 31));
    end
    return w;
  endfunction

  function automatic logic [31:0] random_pc();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'hffff_f000 | ($urandom() & 32'h0000_0fff);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_insn(input logic [31:0] w, input logic [31:0] pc);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {w, pc};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_decoder_empty();
    in_valid <= 1'b0;
    do @(posedge clk); while (decoded_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    rvdec_pkg::dec_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        decoded_q.push_back(decode_insn(in_data));
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          mismatch_count++;
        end else begin
          want = decoded_q.pop_front();
          check_field("insn_kind", want.insn_kind, out_data.insn_kind);
          check_field("dest_reg", want.dest_reg, out_data.dest_reg);
          check_field("src1_reg", want.src1_reg, out_data.src1_reg);
          check_field("src2_reg", want.src2_reg, out_data.src2_reg);
          check_field("immediate", want.immediate, out_data.immediate);
          check_field("target_address", want.target_address, out_data.target_address);
          check_field("csr_number", want.csr_number, out_data.csr_number);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, plus a long hold on request.
  always begin : result_sink
    @(posedge clk);
    if (rx_hold_req > 0) begin
      out_ready <= 1'b0;
      repeat (rx_hold_req) @(posedge clk);
      rx_hold_req = 0;
      out_ready <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic test_corner_words();
    send_insn(32'h0000_0000, 32'h0000_0000);
    send_insn(32'hffff_ffff, 32'hffff_ffff);
    send_insn({7'h7f, 5'h1f, 5'h1f, 3'd7, 5'h1f, rvdec_pkg::OP_LUI}, 32'h0000_0000);
    send_insn({7'h00, 5'h00, 5'h00, 3'd0, 5'h00, rvdec_pkg::OP_AUIPC}, 32'hffff_ffff);
    send_insn({7'h40, 5'h00, 5'h00, 3'd0, 5'h1f, rvdec_pkg::OP_JAL}, 32'h0000_0000);
    send_insn({7'h3f, 5'h1f, 5'h1f, 3'd7, 5'h1f, rvdec_pkg::OP_JAL}, 32'hffff_fffe);
    send_insn({7'h7f, 5'h1f, 5'h1f, 3'd7, 5'h1f, rvdec_pkg::OP_JALR}, 32'h8000_0000);
    send_insn({7'h40, 5'h00, 5'h00, 3'd0, 5'h00, rvdec_pkg::OP_BRANCH}, 32'h0000_0000);
    send_insn({7'h3f, 5'h1f, 5'h1f, 3'd7, 5'h1f, rvdec_pkg::OP_BRANCH}, 32'hffff_ffff);
    send_insn({7'h7f, 5'h1f, 5'h1f, 3'd2, 5'h1f, rvdec_pkg::OP_BRANCH}, 32'h1234_5678);
    send_insn({7'h7f, 5'h1f, 5'h1f, 3'd3, 5'h1f, rvdec_pkg::OP_LOAD}, 32'h0000_0100);
    send_insn({7'h7f, 5'h1f, 5'h1f, 3'd2, 5'h1f, rvdec_pkg::OP_STORE}, 32'h0000_0104);
    send_insn({7'h00, 5'h00, 5'h00, 3'd3, 5'h00, rvdec_pkg::OP_STORE}, 32'h0000_0108);
    send_insn({7'h7f, 5'h1f, 5'h1f, 3'd1, 5'h1f, rvdec_pkg::OP_ALUI}, 32'h0000_010c);
    send_insn({rvdec_pkg::FUNCT7_ALT, 5'h1f, 5'h01, 3'd5, 5'h02, rvdec_pkg::OP_ALUI},
              32'h0000_0110);
    send_insn({7'h01, 5'h1f, 5'h1f, 3'd5, 5'h1f, rvdec_pkg::OP_ALUI}, 32'h0000_0114);
    send_insn({7'h7f, 5'h1f, 5'h1f, 3'd7, 5'h1f, rvdec_pkg::OP_ALUI}, 32'h0000_0118);
    send_insn({rvdec_pkg::FUNCT7_ALT, 5'h1f, 5'h1f, 3'd0, 5'h1f, rvdec_pkg::OP_ALUR},
              32'h0000_011c);
    send_insn({7'h01, 5'h1f, 5'h1f, 3'd0, 5'h1f, rvdec_pkg::OP_ALUR}, 32'h0000_0120);
    send_insn({7'h7f, 5'h1f, 5'h1f, 3'd7, 5'h1f, rvdec_pkg::OP_ALUR}, 32'h0000_0124);
    send_insn(rvdec_pkg::WORD_ECALL, 32'h0000_0128);
    send_insn(rvdec_pkg::WORD_EBREAK, 32'h0000_012c);
    send_insn(rvdec_pkg::WORD_ECALL | 32'h0000_0080, 32'h0000_0130);
    send_insn({7'h7f, 5'h1f, 5'h1f, 3'd4, 5'h1f, rvdec_pkg::OP_SYSTEM}, 32'h0000_0134);
    send_insn({7'h7f, 5'h1f, 5'h1f, 3'd7, 5'h1f, rvdec_pkg::OP_SYSTEM}, 32'h0000_0138);
    send_insn({7'h00, 5'h00, 5'h00, 3'd1, 5'h00, rvdec_pkg::OP_SYSTEM}, 32'h0000_013c);
    wait_decoder_empty();
  endtask

  task automatic test_every_kind();
    for (int k = 1; k <= 45; k++)
      send_insn(encode_kind(rvdec_pkg::insn_kind_e'(k), $urandom()), random_pc());
    wait_decoder_empty();
  endtask

  // Output held off long enough that the block fills and stalls its input.
  task automatic test_output_backpressure();
    idle_en     = 1'b0;
    rx_hold_req = LONG_STALL;
    repeat (40) send_insn(random_word(), random_pc());
    wait_decoder_empty();
    idle_en = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    repeat (20) send_insn(random_word(), random_pc());
    wait_decoder_empty();
    repeat (20) send_insn(random_word(), random_pc());
    wait_decoder_empty();
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 930; i++) begin
      if (i % 100 == 0)
        idle_en = ((i / 100) % 3 != 2);
      send_insn(random_word(), random_pc());
    end
    wait_decoder_empty();
  endtask

  task automatic test_full_rate_stream();
    idle_en = 1'b0;
    repeat (100) send_insn(random_word(), random_pc());
    wait_decoder_empty();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_corner_words();
    test_every_kind();
    test_output_backpressure();
    test_pause_until_drained();
    test_random_mix();
    test_full_rate_stream();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && decoded_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
